// ===== sv/cerq_pkg.sv =====
`timescale 1ns / 1ps
// Package for the coalescing event ring queue: beat structs, op and status codes,
// FSM state type and size constants. No dependencies.
package cerq_pkg;

    localparam int C_DEPTH    = 16;   // ring slots, one always left empty
    localparam int C_ID_W     = 16;
    localparam int C_VALUE_W  = 32;
    localparam int C_SLOT_W   = C_ID_W + C_VALUE_W;
    localparam int C_FQ_DEPTH = 2;    // job queue between front and back

    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    typedef enum logic [2:0] {
        ST_APPEND = 3'd0,
        ST_MERGE  = 3'd1,
        ST_DROP   = 3'd2,
        ST_DEQ    = 3'd3,
        ST_EMPTY  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_ENQ,
        OP_ENQ_UNIQ,
        OP_DEQ
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ_RD,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic                        func;
        logic [C_ID_W-1:0]           event_id;
        logic signed [C_VALUE_W-1:0] event_value;
        logic                        unique_req;
    } t_cmd;

    typedef struct packed {
        logic                        out_valid;
        logic [C_ID_W-1:0]           out_id;
        logic signed [C_VALUE_W-1:0] out_value;
        t_status                     status;
    } t_result;

    // classified job handed from the front to the back
    typedef struct packed {
        t_op                         op;
        logic [C_ID_W-1:0]           id;
        logic signed [C_VALUE_W-1:0] value;
    } t_job;

    // one ring slot as stored in the RAM
    typedef struct packed {
        logic [C_ID_W-1:0]           id;
        logic signed [C_VALUE_W-1:0] value;
    } t_slot;

endpackage

// ===== sv/cerq_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Uses cerq_pkg for default sizes only.
module cerq_ram #(
    parameter int WIDTH = cerq_pkg::C_SLOT_W,
    parameter int DEPTH = cerq_pkg::C_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/cerq_front.sv =====
`timescale 1ns / 1ps
// Front end: takes command beats, classifies them and holds them in a short job queue.
// Depends on cerq_pkg.
module cerq_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  cerq_pkg::t_cmd      i_cmd,
    output logic                o_busy,
    output logic                o_job_valid,
    output cerq_pkg::t_job      o_job,
    input  logic                i_job_pop
);

    localparam int FQ_PTR_W = (cerq_pkg::C_FQ_DEPTH > 1) ? $clog2(cerq_pkg::C_FQ_DEPTH) : 1;
    localparam int FQ_CNT_W = $clog2(cerq_pkg::C_FQ_DEPTH + 1);
    localparam logic [FQ_PTR_W-1:0] FQ_LAST = FQ_PTR_W'(cerq_pkg::C_FQ_DEPTH - 1);
    localparam logic [FQ_CNT_W-1:0] FQ_FULL = FQ_CNT_W'(cerq_pkg::C_FQ_DEPTH);

    cerq_pkg::t_job        r_buf [cerq_pkg::C_FQ_DEPTH];
    logic [FQ_PTR_W-1:0]   r_wr, n_wr;
    logic [FQ_PTR_W-1:0]   r_rd, n_rd;
    logic [FQ_CNT_W-1:0]   r_cnt, n_cnt;
    cerq_pkg::t_job        w_job;
    logic                  w_push;
    logic                  w_pop;

    assign o_busy = (r_cnt == FQ_FULL);
    assign w_push = i_start && !o_busy;
    assign w_pop  = i_job_pop && (r_cnt != '0);

    // classify the command
    always_comb begin
        w_job.id    = i_cmd.event_id;
        w_job.value = i_cmd.event_value;
        if (i_cmd.func == cerq_pkg::FUNC_DEQ) begin
            w_job.op = cerq_pkg::OP_DEQ;
        end else if (i_cmd.unique_req) begin
            w_job.op = cerq_pkg::OP_ENQ_UNIQ;
        end else begin
            w_job.op = cerq_pkg::OP_ENQ;
        end
    end

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == FQ_LAST) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == FQ_LAST) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr] <= w_job;
        end
    end

    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_buf[r_rd];

endmodule

// ===== sv/cerq_back.sv =====
`timescale 1ns / 1ps
// Back end: ring pointers, slot RAM and the sequencer for append, merge search and pop.
// Depends on cerq_pkg and cerq_ram.
module cerq_back #(
    parameter int DEPTH = cerq_pkg::C_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  cerq_pkg::t_job      i_job,
    output logic                o_job_pop,
    output logic                o_done,
    output cerq_pkg::t_result   o_result
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == LAST) ? '0 : p + 1'b1;
    endfunction

    cerq_pkg::t_state   r_state, n_state;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [PTR_W-1:0]   r_tail, n_tail;
    logic [PTR_W-1:0]   r_scan, n_scan;
    cerq_pkg::t_job     r_job, n_job;
    logic               r_done, n_done;
    cerq_pkg::t_result  r_result, n_result;

    logic               w_we;
    logic [PTR_W-1:0]   w_waddr;
    cerq_pkg::t_slot    w_wdata;
    logic               w_re;
    logic [PTR_W-1:0]   w_raddr;
    cerq_pkg::t_slot    w_rdata;

    logic               w_empty;
    logic               w_full;
    logic               w_match;
    logic               w_greater;
    logic [PTR_W-1:0]   w_scan_next;
    logic               w_scan_end;

    cerq_ram #(
        .WIDTH (cerq_pkg::C_SLOT_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_empty     = (r_head == r_tail);
    assign w_full      = (ring_next(r_tail) == r_head);
    assign w_match     = (w_rdata.id == r_job.id);
    assign w_greater   = (r_job.value > w_rdata.value);
    assign w_scan_next = ring_next(r_scan);
    assign w_scan_end  = (w_scan_next == r_tail);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cerq_pkg::S_IDLE: begin
                if (i_job_valid) begin
                    unique case (i_job.op)
                        cerq_pkg::OP_DEQ: begin
                            if (!w_empty) n_state = cerq_pkg::S_DEQ_RD;
                        end
                        cerq_pkg::OP_ENQ_UNIQ: begin
                            if (!w_full && !w_empty) n_state = cerq_pkg::S_SCAN;
                        end
                        default: n_state = cerq_pkg::S_IDLE;
                    endcase
                end
            end
            cerq_pkg::S_DEQ_RD: n_state = cerq_pkg::S_IDLE;
            cerq_pkg::S_SCAN: begin
                if (w_match || w_scan_end) n_state = cerq_pkg::S_IDLE;
            end
            default: n_state = cerq_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        o_job_pop = 1'b0;
        n_head    = r_head;
        n_tail    = r_tail;
        n_scan    = r_scan;
        n_job     = r_job;
        n_done    = 1'b0;
        n_result  = '0;
        w_we      = 1'b0;
        w_waddr   = r_tail;
        w_wdata   = '0;
        w_re      = 1'b0;
        w_raddr   = r_head;
        unique case (r_state)
            cerq_pkg::S_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    unique case (i_job.op)
                        cerq_pkg::OP_DEQ: begin
                            if (w_empty) begin
                                n_done          = 1'b1;
                                n_result.status = cerq_pkg::ST_EMPTY;
                            end else begin
                                w_re = 1'b1;
                            end
                        end
                        default: begin
                            if (w_full) begin
                                n_done          = 1'b1;
                                n_result.status = cerq_pkg::ST_DROP;
                            end else if (i_job.op == cerq_pkg::OP_ENQ_UNIQ && !w_empty) begin
                                w_re   = 1'b1;
                                n_scan = r_head;
                            end else begin
                                w_we            = 1'b1;
                                w_wdata.id      = i_job.id;
                                w_wdata.value   = i_job.value;
                                n_tail          = ring_next(r_tail);
                                n_done          = 1'b1;
                                n_result.status = cerq_pkg::ST_APPEND;
                            end
                        end
                    endcase
                end
            end
            cerq_pkg::S_DEQ_RD: begin
                n_head             = ring_next(r_head);
                n_done             = 1'b1;
                n_result.out_valid = 1'b1;
                n_result.out_id    = w_rdata.id;
                n_result.out_value = w_rdata.value;
                n_result.status    = cerq_pkg::ST_DEQ;
            end
            cerq_pkg::S_SCAN: begin
                if (w_match) begin
                    // keep the larger value, id unchanged
                    w_we            = w_greater;
                    w_waddr         = r_scan;
                    w_wdata.id      = w_rdata.id;
                    w_wdata.value   = r_job.value;
                    n_done          = 1'b1;
                    n_result.status = cerq_pkg::ST_MERGE;
                end else if (w_scan_end) begin
                    w_we            = 1'b1;
                    w_wdata.id      = r_job.id;
                    w_wdata.value   = r_job.value;
                    n_tail          = ring_next(r_tail);
                    n_done          = 1'b1;
                    n_result.status = cerq_pkg::ST_APPEND;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = w_scan_next;
                    n_scan  = w_scan_next;
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cerq_pkg::S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan   <= n_scan;
        r_job    <= n_job;
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== sv/coalescing_event_ring_queue.sv =====
`timescale 1ns / 1ps
// Top level of the coalescing event ring queue: front job queue plus back sequencer.
// Depends on cerq_pkg, cerq_front, cerq_back (and cerq_ram below it).
//
// A command beat is taken when i_start is high and o_busy is low. Every command gives
// exactly one result beat, shown on o_result for a single cycle while o_done is high;
// the receiver cannot stall it, so it must take the beat in that cycle. Commands go
// into a two-deep job queue, so o_busy rises only when two commands are waiting behind
// the one at work. The slot store is one RAM with a single registered read port, and
// that port sets the time per command. In the back end an append, a drop or a dequeue
// from an empty queue is settled in the idle state, a dequeue that pops an event first
// reads the head slot, and a unique enqueue reads pending entries one by one (from the
// oldest onwards) until a match or the tail. A search only runs with room left in the
// ring, so it sees at most DEPTH-2 pending events; with DEPTH-1 events pending the ring
// is full and the enqueue drops at once. The front registers each accepted job before
// the back end sees it. Results leave in command order; a merge with a matching pending
// entry keeps the larger signed value. The slot RAM needs no clearing after reset.
module coalescing_event_ring_queue #(
    parameter int DEPTH = cerq_pkg::C_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  cerq_pkg::t_cmd     i_cmd,
    output logic               o_busy,
    output logic               o_done,
    output cerq_pkg::t_result  o_result
);

    logic           w_job_valid;
    logic           w_job_pop;
    cerq_pkg::t_job w_job;

    // front: accept and classify, buffer up to two jobs
    cerq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_cmd       (i_cmd),
        .o_busy      (o_busy),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_pop   (w_job_pop)
    );

    // back: ring pointers, slot RAM, search and result register
    cerq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_pop   (w_job_pop),
        .o_done      (o_done),
        .o_result    (o_result)
    );

endmodule

// ===== sv/cerq_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the coalescing event ring queue, bound to the top level.
// Depends on cerq_pkg.
module cerq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input cerq_pkg::t_cmd     i_cmd,
    input logic               o_busy,
    input logic               o_done,
    input cerq_pkg::t_result  o_result
);

    logic [3:0] r_pending, n_pending;
    logic       w_accept;

    assign w_accept = i_start && !o_busy;

    always_comb begin
        n_pending = r_pending;
        if (w_accept && !o_done) begin
            n_pending = r_pending + 1'b1;
        end else if (o_done && !w_accept) begin
            n_pending = r_pending - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    // no result beat without an outstanding command
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_pending != 4'd0))
        else $error("result beat with no command outstanding");

    // busy only with at least two commands outstanding, as with the job queue full
    a_busy_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> (r_pending >= 4'd2))
        else $error("busy with too few commands outstanding");

    // a presented event is a dequeue, anything else carries no event
    a_valid_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.out_valid == (o_result.status == cerq_pkg::ST_DEQ)))
        else $error("out_valid and status disagree");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.out_valid) |-> (o_result.out_id == '0 && o_result.out_value == '0))
        else $error("event fields not zero without out_valid");

endmodule

bind coalescing_event_ring_queue cerq_checker u_cerq_checker (.*);

// ===== tb/coalescing_event_ring_queue_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for coalescing_event_ring_queue: directed corner cases, then random
// command traffic, each result beat checked against an in-bench ring model.
// Depends on cerq_pkg and the RTL of the block.

// Ring model of the queue plus the store of awaited result beats.
class event_queue_scoreboard;
    cerq_pkg::t_slot   ring [cerq_pkg::C_DEPTH];
    int unsigned       head_idx;
    int unsigned       tail_idx;
    cerq_pkg::t_result awaited [$];
    int unsigned       n_errors;
    int unsigned       n_checked;
    int unsigned       n_commands;
    int unsigned       status_seen [5];

    function new();
        head_idx   = 0;
        tail_idx   = 0;
        n_errors   = 0;
        n_checked  = 0;
        n_commands = 0;
        foreach (status_seen[k]) status_seen[k] = 0;
    endfunction

    function int unsigned ring_step(int unsigned p);
        return (p + 1) % cerq_pkg::C_DEPTH;
    endfunction

    // Work out the result of an accepted command and update the ring.
    function void note_command(cerq_pkg::t_cmd c);
        cerq_pkg::t_result r;
        int unsigned       p;
        bit                merged;
        r      = '0;
        merged = 1'b0;
        n_commands++;
        if (c.func == cerq_pkg::FUNC_ENQ) begin
            if (ring_step(tail_idx) == head_idx) begin
                r.status = cerq_pkg::ST_DROP;
            end else begin
                if (c.unique_req) begin
                    p = head_idx;
                    while (p != tail_idx && !merged) begin
                        if (ring[p].id == c.event_id) begin
                            if ($signed(c.event_value) > $signed(ring[p].value))
                                ring[p].value = c.event_value;
                            merged = 1'b1;
                        end else begin
                            p = ring_step(p);
                        end
                    end
                end
                if (merged) begin
                    r.status = cerq_pkg::ST_MERGE;
                end else begin
                    ring[tail_idx].id    = c.event_id;
                    ring[tail_idx].value = c.event_value;
                    tail_idx             = ring_step(tail_idx);
                    r.status             = cerq_pkg::ST_APPEND;
                end
            end
        end else begin
            if (head_idx == tail_idx) begin
                r.status = cerq_pkg::ST_EMPTY;
            end else begin
                r.out_valid = 1'b1;
                r.out_id    = ring[head_idx].id;
                r.out_value = ring[head_idx].value;
                head_idx    = ring_step(head_idx);
                r.status    = cerq_pkg::ST_DEQ;
            end
        end
        status_seen[r.status]++;
        awaited.push_back(r);
    endfunction

    function void check_result(cerq_pkg::t_result got);
        cerq_pkg::t_result want;
        if (awaited.size() == 0) begin
            n_errors++;
            $display("%0t: unexpected result beat: valid=%0b id=%h value=%0d status=%0d",
                     $time, got.out_valid, got.out_id, $signed(got.out_value), got.status);
            return;
        end
        want = awaited.pop_front();
        n_checked++;
        if (got.out_valid !== want.out_valid || got.out_id !== want.out_id ||
            got.out_value !== want.out_value || got.status !== want.status) begin
            n_errors++;
            $display({"%0t: mismatch: expected valid=%0b id=%h value=%0d status=%0d,",
                      " got valid=%0b id=%h value=%0d status=%0d"}, $time,
                     want.out_valid, want.out_id, $signed(want.out_value), want.status,
                     got.out_valid, got.out_id, $signed(got.out_value), got.status);
        end
    endfunction

    function void close_out();
        if (awaited.size() != 0) begin
            $display("%0t: %0d expected result beats never arrived", $time, awaited.size());
            n_errors += awaited.size();
        end
    endfunction
endclass

module coalescing_event_ring_queue_tb;

    // Generous ceiling: ~1725 commands, each at worst a longest search queued behind two
    // others, plus long sender gaps in the idle phases.
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned N_RANDOM    = 1700;
    localparam int unsigned N_PHASES    = 4;
    localparam int unsigned BURST_LEN   = 40;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              i_start = 1'b0;
    cerq_pkg::t_cmd    i_cmd   = '0;
    logic              o_busy;
    logic              o_done;
    cerq_pkg::t_result o_result;

    int unsigned cycle_count = 0;

    event_queue_scoreboard sb;

    coalescing_event_ring_queue i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_cmd   (i_cmd),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: a hung block or a lost result beat ends up here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Monitor. Everything is sampled at the rising edge, before the nonblocking updates of
    // that edge land, so the values seen are the ones the block itself acted on. The
    // command is noted first: a result beat in the same cycle can only belong to an older
    // command, and it pops the front of the store.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy)
                sb.note_command(i_cmd);
            if (o_done)
                sb.check_result(o_result);
        end
    end

    function automatic cerq_pkg::t_cmd mk_cmd(logic func, logic [15:0] id,
                                              logic [31:0] value, logic uniq);
        cerq_pkg::t_cmd c;
        c.func        = func;
        c.event_id    = id;
        c.event_value = value;
        c.unique_req  = uniq;
        return c;
    endfunction

    // Random command. Ids come mostly from a small pool so that unique enqueues find
    // matches; values lean on the signed extremes and on values around zero.
    function automatic cerq_pkg::t_cmd random_cmd(int unsigned enq_pct);
        cerq_pkg::t_cmd c;
        int unsigned    pick;
        c.func       = ($urandom_range(99) < enq_pct) ? cerq_pkg::FUNC_ENQ : cerq_pkg::FUNC_DEQ;
        c.unique_req = 1'($urandom_range(1));
        pick = $urandom_range(9);
        if (pick < 6)
            c.event_id = 16'($urandom_range(7));
        else if (pick < 9)
            c.event_id = 16'($urandom_range(16'hFFFF));
        else
            c.event_id = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        pick = $urandom_range(9);
        case (pick)
            7:       c.event_value = 32'h7FFF_FFFF;
            8:       c.event_value = 32'h8000_0000;
            9:       c.event_value = $urandom_range(4) - 2;
            default: c.event_value = $urandom;
        endcase
        return c;
    endfunction

    // One command beat. Before it, the sender stays idle cycle by cycle with the given
    // odds. i_start is left high across back-to-back beats and only dropped for a gap.
    task automatic send_command(input cerq_pkg::t_cmd c, input int unsigned idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_cmd   <= c;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    // Directed opening: empty dequeue, signed extremes of the value, merges that do and
    // do not raise the value, a duplicate appended without the unique flag, a merge into
    // that duplicate, a full ring dropping both a plain and a would-be merge.
    task automatic run_directed();
        send_command(mk_cmd(cerq_pkg::FUNC_DEQ, 16'hFFFF, 32'hFFFF_FFFF, 1'b1), 0);  // empty
        send_command(mk_cmd(cerq_pkg::FUNC_ENQ, 16'h0000, 32'h8000_0000, 1'b0), 0);
        send_command(mk_cmd(cerq_pkg::FUNC_ENQ, 16'hFFFF, 32'h7FFF_FFFF, 1'b1), 0);  // no match
        send_command(mk_cmd(cerq_pkg::FUNC_ENQ, 16'h0000, 32'h7FFF_FFFF, 1'b1), 0);  // raises
        send_command(mk_cmd(cerq_pkg::FUNC_ENQ, 16'h0000, 32'hFFFF_FFFF, 1'b1), 0);  // keeps max
        send_command(mk_cmd(cerq_pkg::FUNC_ENQ, 16'h0000, 32'd5, 1'b0), 0);          // duplicate
        send_command(mk_cmd(cerq_pkg::FUNC_ENQ, 16'hFFFF, 32'h8000_0000, 1'b1), 0);
        send_command(mk_cmd(cerq_pkg::FUNC_DEQ, 16'h0000, 32'h0, 1'b0), 0);
        send_command(mk_cmd(cerq_pkg::FUNC_ENQ, 16'h0000, 32'd3, 1'b1), 0);          // merges
        // two pending now; top the ring up to DEPTH-1 entries
        for (int k = 0; k < cerq_pkg::C_DEPTH - 3; k++)
            send_command(mk_cmd(cerq_pkg::FUNC_ENQ, 16'h0100 + k[15:0],
                                (k % 2) ? 32'h8000_0000 + k : 32'h7FFF_FFF0 + k,
                                k[0]), 0);
        send_command(mk_cmd(cerq_pkg::FUNC_ENQ, 16'h0000, 32'h7FFF_FFFF, 1'b1), 0);  // drop
        send_command(mk_cmd(cerq_pkg::FUNC_ENQ, 16'h5A5A, 32'h1234_5678, 1'b0), 0);  // drop
        send_command(mk_cmd(cerq_pkg::FUNC_DEQ, 16'h0000, 32'h0, 1'b0), 0);
    endtask

    initial begin
        // sender idle odds per phase: none, heavy, none, light. The receiver has no
        // back-pressure, so the phases only shape the sender side.
        int unsigned phase_idle [N_PHASES];
        int unsigned idle_pct;
        int unsigned enq_pct;
        int unsigned n_sent;
        phase_idle = '{0, 59, 0, 10};
        sb = new();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        // Random part in bursts. Each burst picks a fill bias so the ring swings
        // between full and empty and wraps many times; some bursts of the idle phases
        // run flat out so gaps and back-to-back beats meet every stage of a search.
        n_sent = 0;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            while (n_sent < (ph + 1) * N_RANDOM / N_PHASES) begin
                case ($urandom_range(2))
                    0:       enq_pct = 85;
                    1:       enq_pct = 50;
                    default: enq_pct = 20;
                endcase
                idle_pct = ($urandom_range(3) == 0) ? 0 : phase_idle[ph];
                for (int b = 0; b < BURST_LEN; b++) begin
                    send_command(random_cmd(enq_pct), idle_pct);
                    n_sent++;
                end
            end
        end
        i_start <= 1'b0;

        // Drain: every beat owed must arrive (the watchdog covers a hang), then a further wait
        // in case anything stray follows.
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (4 * cerq_pkg::C_DEPTH) @(posedge i_clk);
        sb.close_out();

        $display("%0d commands: %0d appended, %0d merged, %0d dropped full,",
                 sb.n_commands, sb.status_seen[cerq_pkg::ST_APPEND],
                 sb.status_seen[cerq_pkg::ST_MERGE], sb.status_seen[cerq_pkg::ST_DROP]);
        $display("  %0d dequeued, %0d empty; %0d result beats checked, %0d errors, %0d cycles",
                 sb.status_seen[cerq_pkg::ST_DEQ], sb.status_seen[cerq_pkg::ST_EMPTY],
                 sb.n_checked, sb.n_errors, cycle_count);
        if (sb.n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
